// File: rtl/core/variable_record_ring_space_manager_assert.svh
// Assertion macros used by the checker vrrsm_chk.
`ifndef VARIABLE_RECORD_RING_SPACE_MANAGER_ASSERT_SVH
`define VARIABLE_RECORD_RING_SPACE_MANAGER_ASSERT_SVH

// Checked on every edge outside reset.
`define VRRSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define VRRSM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/vrrsm_pkg.sv
`default_nettype none
package vrrsm_pkg;

	localparam int unsigned BUF_BYTES    = 262144;
	localparam int unsigned ALIGN_BYTES  = 8;
	localparam int unsigned HEADER_BYTES = 56;
	localparam int unsigned MAX_TEXT     = 992;

	localparam int unsigned TEXT_W = 10;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned OFF_W  = 18;
	localparam int unsigned LEN_W  = 11;
	localparam int unsigned SEQ_W  = 64;
	localparam int unsigned DROP_W = 13;

	localparam int unsigned STORE_DEPTH = BUF_BYTES / ALIGN_BYTES;
	localparam int unsigned SLOT_W      = $clog2(STORE_DEPTH);
	localparam int unsigned ALIGN_SH    = $clog2(ALIGN_BYTES);
	localparam int unsigned DCNT_W      = SLOT_W + 1;
	localparam int unsigned FREE_W      = OFF_W + 1;

	typedef enum logic [STAT_W-1:0] {
		ST_APPENDED = 2'd0,
		ST_RETURNED = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_CHECK,
		S_A_LEN,
		S_A_LEN0,
		S_A_WRITE,
		S_R_SYNC,
		S_R_CHECK,
		S_R_LEN,
		S_R_LEN0
	} state_t;

	typedef enum logic [1:0] {
		RA_OLDEST,
		RA_READER,
		RA_ZERO
	} raddr_sel_t;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_APPEND,
		OUT_READ,
		OUT_READ0,
		OUT_EMPTY
	} out_sel_t;

	typedef struct packed {
		logic       capture;
		logic       drop_adv;
		logic       drop_adv0;
		logic       place_wrap;
		logic       rsync;
		logic       rd_en;
		raddr_sel_t rd_sel;
		out_sel_t   out_sel;
	} cmd_t;

	typedef struct packed {
		logic need_drop;
		logic wrap_needed;
		logic len_zero;
		logic rd_avail;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/vrrsm_ram.sv
`default_nettype none
module vrrsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/core/vrrsm_dp.sv
`default_nettype none
module vrrsm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [vrrsm_pkg::TEXT_W-1:0]   text_bytes,
	input  vrrsm_pkg::cmd_t                cmd,
	output vrrsm_pkg::sts_t                sts,
	output logic [vrrsm_pkg::STAT_W-1:0]   status,
	output logic [vrrsm_pkg::OFF_W-1:0]    offset,
	output logic [vrrsm_pkg::LEN_W-1:0]    record_len,
	output logic [vrrsm_pkg::SEQ_W-1:0]    seq_number,
	output logic [vrrsm_pkg::DROP_W-1:0]   dropped,
	output logic                           wrapped
);

	localparam int unsigned OFF_W  = vrrsm_pkg::OFF_W;
	localparam int unsigned LEN_W  = vrrsm_pkg::LEN_W;
	localparam int unsigned SEQ_W  = vrrsm_pkg::SEQ_W;
	localparam int unsigned FREE_W = vrrsm_pkg::FREE_W;
	localparam int unsigned SLOT_W = vrrsm_pkg::SLOT_W;
	localparam int unsigned DCNT_W = vrrsm_pkg::DCNT_W;
	localparam int unsigned ASH    = vrrsm_pkg::ALIGN_SH;

	logic [OFF_W-1:0]  oldest_off_q, next_off_q, rd_off_q;
	logic [SEQ_W-1:0]  oldest_seq_q, next_seq_q, rd_seq_q;
	logic [LEN_W-1:0]  size_q;
	logic [DCNT_W-1:0] drops_q;
	logic              wrapped_q;

	logic [vrrsm_pkg::STAT_W-1:0] status_q;
	logic [OFF_W-1:0]             offset_q;
	logic [LEN_W-1:0]             record_len_q;
	logic [SEQ_W-1:0]             seq_number_q;
	logic [vrrsm_pkg::DROP_W-1:0] dropped_q;
	logic                         wrapped_out_q;

	logic [LEN_W-1:0]  text_ext, text_sat, size_sum, size_new;
	logic [FREE_W-1:0] next_ext, oldest_ext, tail, free_bytes, room;
	logic              ram_we, ram_re;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr;
	logic [LEN_W-1:0]  ram_wdata, ram_rdata;

	always_comb begin
		text_ext = LEN_W'(text_bytes);
		text_sat = (text_ext > LEN_W'(vrrsm_pkg::MAX_TEXT)) ?
			LEN_W'(vrrsm_pkg::MAX_TEXT) : text_ext;
		size_sum = text_sat +
			LEN_W'(vrrsm_pkg::HEADER_BYTES + vrrsm_pkg::ALIGN_BYTES - 1);
		size_new = size_sum & ~LEN_W'(vrrsm_pkg::ALIGN_BYTES - 1);
	end

	always_comb begin
		next_ext   = FREE_W'(next_off_q);
		oldest_ext = FREE_W'(oldest_off_q);
		tail       = FREE_W'(vrrsm_pkg::BUF_BYTES) - next_ext;
		if (next_off_q > oldest_off_q) begin
			free_bytes = (tail > oldest_ext) ? tail : oldest_ext;
		end else begin
			free_bytes = oldest_ext - next_ext;
		end
		room = FREE_W'(size_q) + FREE_W'(vrrsm_pkg::HEADER_BYTES);
		sts.need_drop   = (oldest_seq_q < next_seq_q) &&
			(drops_q < DCNT_W'(vrrsm_pkg::STORE_DEPTH)) && !(free_bytes > room);
		sts.wrap_needed = (next_ext + room) >= FREE_W'(vrrsm_pkg::BUF_BYTES);
		sts.len_zero    = (ram_rdata == '0);
		sts.rd_avail    = rd_seq_q < next_seq_q;
	end

	always_comb begin
		ram_we    = cmd.place_wrap || (cmd.out_sel == vrrsm_pkg::OUT_APPEND);
		ram_waddr = next_off_q[OFF_W-1:ASH];
		ram_wdata = cmd.place_wrap ? '0 : size_q;
		ram_re    = cmd.rd_en;
		case (cmd.rd_sel)
			vrrsm_pkg::RA_OLDEST: ram_raddr = oldest_off_q[OFF_W-1:ASH];
			vrrsm_pkg::RA_READER: ram_raddr = rd_off_q[OFF_W-1:ASH];
			default:              ram_raddr = '0;
		endcase
	end

	vrrsm_ram #(
		.WIDTH(LEN_W),
		.DEPTH(vrrsm_pkg::STORE_DEPTH)
	) u_len_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_off_q <= '0;
			oldest_seq_q <= '0;
			next_off_q   <= '0;
			next_seq_q   <= '0;
			rd_off_q     <= '0;
			rd_seq_q     <= '0;
			size_q       <= '0;
			drops_q      <= '0;
			wrapped_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				size_q    <= size_new;
				drops_q   <= '0;
				wrapped_q <= 1'b0;
			end
			if (cmd.drop_adv) begin
				oldest_off_q <= oldest_off_q + OFF_W'(ram_rdata);
				oldest_seq_q <= oldest_seq_q + SEQ_W'(1);
				drops_q      <= drops_q + DCNT_W'(1);
			end
			if (cmd.drop_adv0) begin
				oldest_off_q <= OFF_W'(ram_rdata);
				oldest_seq_q <= oldest_seq_q + SEQ_W'(1);
				drops_q      <= drops_q + DCNT_W'(1);
			end
			if (cmd.place_wrap) begin
				next_off_q <= '0;
				wrapped_q  <= 1'b1;
			end
			if (cmd.rsync && (rd_seq_q < oldest_seq_q)) begin
				rd_seq_q <= oldest_seq_q;
				rd_off_q <= oldest_off_q;
			end
			case (cmd.out_sel)
				vrrsm_pkg::OUT_APPEND: begin
					next_off_q <= next_off_q + OFF_W'(size_q);
					next_seq_q <= next_seq_q + SEQ_W'(1);
				end
				vrrsm_pkg::OUT_READ: begin
					rd_off_q <= rd_off_q + OFF_W'(ram_rdata);
					rd_seq_q <= rd_seq_q + SEQ_W'(1);
				end
				vrrsm_pkg::OUT_READ0: begin
					rd_off_q <= OFF_W'(ram_rdata);
					rd_seq_q <= rd_seq_q + SEQ_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			vrrsm_pkg::OUT_APPEND: begin
				status_q      <= vrrsm_pkg::ST_APPENDED;
				offset_q      <= next_off_q;
				record_len_q  <= size_q;
				seq_number_q  <= next_seq_q;
				dropped_q     <= drops_q[vrrsm_pkg::DROP_W-1:0];
				wrapped_out_q <= wrapped_q;
			end
			vrrsm_pkg::OUT_READ: begin
				status_q      <= vrrsm_pkg::ST_RETURNED;
				offset_q      <= rd_off_q;
				record_len_q  <= ram_rdata;
				seq_number_q  <= rd_seq_q;
				dropped_q     <= '0;
				wrapped_out_q <= 1'b0;
			end
			vrrsm_pkg::OUT_READ0: begin
				status_q      <= vrrsm_pkg::ST_RETURNED;
				offset_q      <= '0;
				record_len_q  <= ram_rdata;
				seq_number_q  <= rd_seq_q;
				dropped_q     <= '0;
				wrapped_out_q <= 1'b0;
			end
			vrrsm_pkg::OUT_EMPTY: begin
				status_q      <= vrrsm_pkg::ST_EMPTY;
				offset_q      <= '0;
				record_len_q  <= '0;
				seq_number_q  <= '0;
				dropped_q     <= '0;
				wrapped_out_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign status     = status_q;
	assign offset     = offset_q;
	assign record_len = record_len_q;
	assign seq_number = seq_number_q;
	assign dropped    = dropped_q;
	assign wrapped    = wrapped_out_q;

endmodule
`default_nettype wire

// File: rtl/core/vrrsm_ctrl.sv
`default_nettype none
module vrrsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            req_type,
	output logic            out_valid,
	input  logic            out_stall,
	input  vrrsm_pkg::sts_t sts,
	output vrrsm_pkg::cmd_t cmd
);

	vrrsm_pkg::state_t state_q, state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrrsm_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_sel != vrrsm_pkg::OUT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = vrrsm_pkg::RA_OLDEST;
		cmd.out_sel = vrrsm_pkg::OUT_NONE;
		unique case (state_q)
			vrrsm_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = req_type ? vrrsm_pkg::S_R_SYNC : vrrsm_pkg::S_A_CHECK;
				end
			end
			vrrsm_pkg::S_A_CHECK: begin
				if (sts.need_drop) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = vrrsm_pkg::RA_OLDEST;
					state_d    = vrrsm_pkg::S_A_LEN;
				end else begin
					cmd.place_wrap = sts.wrap_needed;
					state_d        = vrrsm_pkg::S_A_WRITE;
				end
			end
			vrrsm_pkg::S_A_LEN: begin
				if (sts.len_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = vrrsm_pkg::RA_ZERO;
					state_d    = vrrsm_pkg::S_A_LEN0;
				end else begin
					cmd.drop_adv = 1'b1;
					state_d      = vrrsm_pkg::S_A_CHECK;
				end
			end
			vrrsm_pkg::S_A_LEN0: begin
				cmd.drop_adv0 = 1'b1;
				state_d       = vrrsm_pkg::S_A_CHECK;
			end
			vrrsm_pkg::S_A_WRITE: begin
				if (out_free) begin
					cmd.out_sel = vrrsm_pkg::OUT_APPEND;
					state_d     = vrrsm_pkg::S_IDLE;
				end
			end
			vrrsm_pkg::S_R_SYNC: begin
				cmd.rsync = 1'b1;
				state_d   = vrrsm_pkg::S_R_CHECK;
			end
			vrrsm_pkg::S_R_CHECK: begin
				if (sts.rd_avail) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = vrrsm_pkg::RA_READER;
					state_d    = vrrsm_pkg::S_R_LEN;
				end else if (out_free) begin
					cmd.out_sel = vrrsm_pkg::OUT_EMPTY;
					state_d     = vrrsm_pkg::S_IDLE;
				end
			end
			vrrsm_pkg::S_R_LEN: begin
				if (sts.len_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = vrrsm_pkg::RA_ZERO;
					state_d    = vrrsm_pkg::S_R_LEN0;
				end else if (out_free) begin
					cmd.out_sel = vrrsm_pkg::OUT_READ;
					state_d     = vrrsm_pkg::S_IDLE;
				end
			end
			vrrsm_pkg::S_R_LEN0: begin
				if (out_free) begin
					cmd.out_sel = vrrsm_pkg::OUT_READ0;
					state_d     = vrrsm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = vrrsm_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != vrrsm_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/variable_record_ring_space_manager.sv
// Space manager for a ring of variable-length records with drop-oldest. Each request is
// an append (req_type 0, text_bytes bytes of text, saturated to 992) or a read of the next
// unread record (req_type 1); each gives exactly one result on the output channel. Records
// take 56 header bytes plus text, rounded up to 8 bytes, in a 256 KiB ring; a 32K x 11
// length memory holds one padded length per 8-byte slot. An append checks the space, drops
// oldest records while it is short, one registered length read each (two for a wrap
// marker), then writes; a read moves the reader past dropped records, checks for an unread
// one and reads its length (twice at a wrap marker), or reports empty. Requests are taken
// one at a time; a finished result waits in the output register while the next request is
// accepted and worked on. The length memory is not cleared at reset.
`default_nettype none
module variable_record_ring_space_manager (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [vrrsm_pkg::TEXT_W-1:0]   text_bytes,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [vrrsm_pkg::STAT_W-1:0]   status,
	output logic [vrrsm_pkg::OFF_W-1:0]    offset,
	output logic [vrrsm_pkg::LEN_W-1:0]    record_len,
	output logic [vrrsm_pkg::SEQ_W-1:0]    seq_number,
	output logic [vrrsm_pkg::DROP_W-1:0]   dropped,
	output logic                           wrapped
);

	vrrsm_pkg::cmd_t cmd;
	vrrsm_pkg::sts_t sts;

	vrrsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vrrsm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_bytes (text_bytes),
		.cmd        (cmd),
		.sts        (sts),
		.status     (status),
		.offset     (offset),
		.record_len (record_len),
		.seq_number (seq_number),
		.dropped    (dropped),
		.wrapped    (wrapped)
	);

endmodule
`default_nettype wire

// File: rtl/core/vrrsm_chk.sv
`default_nettype none
`include "variable_record_ring_space_manager_assert.svh"
module vrrsm_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           req_type,
	input logic [vrrsm_pkg::TEXT_W-1:0]   text_bytes,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [vrrsm_pkg::STAT_W-1:0]   status,
	input logic [vrrsm_pkg::OFF_W-1:0]    offset,
	input logic [vrrsm_pkg::LEN_W-1:0]    record_len,
	input logic [vrrsm_pkg::SEQ_W-1:0]    seq_number,
	input logic [vrrsm_pkg::DROP_W-1:0]   dropped,
	input logic                           wrapped
);

	logic unused_in;
	assign unused_in = in_valid ^ in_stall ^ req_type ^ (^text_bytes);

	// stalled result holds
	`VRRSM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(seq_number) && $stable(offset), "result changed under stall")

	// empty read result is all zero
	`VRRSM_ASSERT(a_empty_zero, out_valid && (status == vrrsm_pkg::ST_EMPTY) |-> (offset == '0) && (record_len == '0) && (seq_number == '0) && (dropped == '0) && !wrapped, "empty result not cleared")

	// reads never report drops or wraps
	`VRRSM_ASSERT(a_read_flags, out_valid && (status == vrrsm_pkg::ST_RETURNED) |-> (dropped == '0) && !wrapped, "read result with append flags")

	// appended record is aligned, holds a header, and restarts at 0 after a wrap
	`VRRSM_ASSERT(a_append_shape, out_valid && (status == vrrsm_pkg::ST_APPENDED) |-> (record_len % vrrsm_pkg::ALIGN_BYTES == 0) && (record_len >= vrrsm_pkg::HEADER_BYTES) && (offset % vrrsm_pkg::ALIGN_BYTES == 0) && (!wrapped || (offset == '0)), "bad append placement")

	// no result after an edge in reset
	`VRRSM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid in reset")

endmodule

bind variable_record_ring_space_manager vrrsm_chk u_chk (.*);
`default_nettype wire

// File: tb/sv/variable_record_ring_space_manager_tb.sv
`default_nettype none
module variable_record_ring_space_manager_tb;
	import vrrsm_pkg::*;

	localparam bit REQ_APPEND = 1'b0;
	localparam bit REQ_READ   = 1'b1;
	localparam int PLAN_N     = 25;
	localparam int PHASES     = 5;

	typedef struct {
		logic [STAT_W-1:0] st;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic [SEQ_W-1:0]  seq;
		logic [DROP_W-1:0] drops;
		logic              wrap;
	} outcome_t;

	typedef struct {
		bit              rt;
		bit [TEXT_W-1:0] tl;
		bit              typed;
		outcome_t        want;
	} plan_row_t;

	typedef enum int {
		MIX_BALANCED,
		MIX_APPEND_BURST,
		MIX_READ_HEAVY
	} mix_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_type = 1'b0;
	logic [TEXT_W-1:0] text_bytes = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [OFF_W-1:0]  offset;
	logic [LEN_W-1:0]  record_len;
	logic [SEQ_W-1:0]  seq_number;
	logic [DROP_W-1:0] dropped;
	logic              wrapped;

	variable_record_ring_space_manager dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.text_bytes (text_bytes),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.offset     (offset),
		.record_len (record_len),
		.seq_number (seq_number),
		.dropped    (dropped),
		.wrapped    (wrapped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#8000000;
		$display("variable_record_ring_space_manager_tb failed");
		$finish;
	end

	// ring bookkeeping mirror
	bit [OFF_W-1:0] ring_oldest_off = '0;
	bit [SEQ_W-1:0] ring_oldest_seq = '0;
	bit [OFF_W-1:0] ring_next_off   = '0;
	bit [SEQ_W-1:0] ring_next_seq   = '0;
	bit [OFF_W-1:0] ring_reader_off = '0;
	bit [SEQ_W-1:0] ring_reader_seq = '0;
	bit [LEN_W-1:0] len_mem [STORE_DEPTH];

	outcome_t outcome_q [$];
	int unsigned errors = 0;

	function automatic bit [OFF_W-1:0] record_after(input bit [OFF_W-1:0] off);
		bit [LEN_W-1:0] len;
		len = len_mem[off / ALIGN_BYTES];
		if (len == 0)
			return OFF_W'(len_mem[0]);
		return off + OFF_W'(len);
	endfunction

	function automatic outcome_t ring_service(input bit rt, input bit [TEXT_W-1:0] tl);
		outcome_t r;
		int unsigned t, size, drops, free_b, tail;
		bit [OFF_W-1:0] at;
		r = '{st: ST_EMPTY, off: '0, len: '0, seq: '0, drops: '0, wrap: 1'b0};
		if (rt == REQ_APPEND) begin
			t = tl;
			if (t > MAX_TEXT)
				t = MAX_TEXT;
			size = (HEADER_BYTES + t + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
			drops = 0;
			while (ring_oldest_seq < ring_next_seq && drops < STORE_DEPTH) begin
				if (ring_next_off > ring_oldest_off) begin
					tail = BUF_BYTES - ring_next_off;
					free_b = (tail > ring_oldest_off) ? tail : ring_oldest_off;
				end else begin
					free_b = ring_oldest_off - ring_next_off;
				end
				if (free_b > size + HEADER_BYTES)
					break;
				ring_oldest_off = record_after(ring_oldest_off);
				ring_oldest_seq++;
				drops++;
			end
			if (ring_next_off + size + HEADER_BYTES >= BUF_BYTES) begin
				len_mem[ring_next_off / ALIGN_BYTES] = '0;
				ring_next_off = '0;
				r.wrap = 1'b1;
			end
			len_mem[ring_next_off / ALIGN_BYTES] = LEN_W'(size);
			r.st    = ST_APPENDED;
			r.off   = ring_next_off;
			r.len   = LEN_W'(size);
			r.seq   = ring_next_seq;
			r.drops = DROP_W'(drops);
			ring_next_off = OFF_W'(ring_next_off + size);
			ring_next_seq++;
		end else begin
			// reader overrun: jump to oldest surviving record
			if (ring_reader_seq < ring_oldest_seq) begin
				ring_reader_seq = ring_oldest_seq;
				ring_reader_off = ring_oldest_off;
			end
			if (ring_reader_seq < ring_next_seq) begin
				at = ring_reader_off;
				if (len_mem[at / ALIGN_BYTES] == 0)
					at = '0;
				r.st  = ST_RETURNED;
				r.off = at;
				r.len = len_mem[at / ALIGN_BYTES];
				r.seq = ring_reader_seq;
				ring_reader_off = record_after(ring_reader_off);
				ring_reader_seq++;
			end
		end
		return r;
	endfunction

	task automatic field_check(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : watch_results
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d offset %0d",
					$time, status, offset);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				field_check("status", want.st, status);
				field_check("offset", want.off, offset);
				field_check("record_len", want.len, record_len);
				field_check("seq_number", want.seq, seq_number);
				field_check("dropped", want.drops, dropped);
				field_check("wrapped", want.wrap, wrapped);
			end
		end
	end

	// output-side backpressure: short stalls, a few long ones, quiet stretches
	int unsigned stall_hold = 0;
	always @(posedge clk) begin : stall_gen
		int unsigned pick;
		if (stall_hold == 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(1, 20);
			end else if (pick < 90) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(1, 3);
			end else if (pick < 97) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(100, 400);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(20, 60);
			end
		end else begin
			stall_hold--;
		end
	end

	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// called at a rising edge; returns at the accepting edge or after the gap
	task automatic send_req(input bit rt, input bit [TEXT_W-1:0] tl, input bit typed,
			input outcome_t want, input bit quiet);
		outcome_t pred;
		int unsigned gap;
		in_valid <= 1'b1;
		req_type <= rt;
		text_bytes <= tl;
		do
			@(posedge clk);
		while (in_stall);
		pred = ring_service(rt, tl);
		outcome_q.push_back(typed ? want : pred);
		gap = pick_gap(quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic outcome_t appended(input int unsigned off, input int unsigned len,
			input int unsigned seq);
		outcome_t r;
		r = '{st: ST_APPENDED, off: OFF_W'(off), len: LEN_W'(len), seq: SEQ_W'(seq),
			drops: '0, wrap: 1'b0};
		return r;
	endfunction

	outcome_t none_left;
	outcome_t anyv;
	plan_row_t plan [PLAN_N];
	mix_t phase_mix [PHASES] = '{MIX_BALANCED, MIX_APPEND_BURST, MIX_READ_HEAVY,
		MIX_BALANCED, MIX_APPEND_BURST};
	int unsigned phase_len [PHASES] = '{200, 350, 150, 200, 300};

	initial begin : stimulus
		bit rt;
		bit [TEXT_W-1:0] tl;
		bit quiet;
		int unsigned p, rd_pct;
		none_left = '{st: ST_EMPTY, off: '0, len: '0, seq: '0, drops: '0, wrap: 1'b0};
		anyv = none_left;
		plan[0]  = '{REQ_READ,   10'd0,    1'b1, none_left};
		plan[1]  = '{REQ_READ,   10'd1023, 1'b1, none_left};
		plan[2]  = '{REQ_APPEND, 10'd0,    1'b1, appended(0, 56, 0)};
		plan[3]  = '{REQ_APPEND, 10'd1023, 1'b1, appended(56, 1048, 1)};
		plan[4]  = '{REQ_APPEND, 10'd992,  1'b1, appended(1104, 1048, 2)};
		plan[5]  = '{REQ_APPEND, 10'd993,  1'b1, appended(2152, 1048, 3)};
		plan[6]  = '{REQ_APPEND, 10'd1,    1'b1, appended(3200, 64, 4)};
		plan[7]  = '{REQ_APPEND, 10'd8,    1'b1, appended(3264, 64, 5)};
		plan[8]  = '{REQ_APPEND, 10'd9,    1'b1, appended(3328, 72, 6)};
		plan[9]  = '{REQ_APPEND, 10'd512,  1'b1, appended(3400, 568, 7)};
		plan[10] = '{REQ_READ,   10'd0,    1'b1,
			'{st: ST_RETURNED, off: '0, len: LEN_W'(56), seq: '0, drops: '0, wrap: 1'b0}};
		plan[11] = '{REQ_READ,   10'd682,  1'b1,
			'{st: ST_RETURNED, off: OFF_W'(56), len: LEN_W'(1048), seq: SEQ_W'(1),
				drops: '0, wrap: 1'b0}};
		plan[12] = '{REQ_APPEND, 10'd341,  1'b0, anyv};
		plan[13] = '{REQ_APPEND, 10'd682,  1'b0, anyv};
		for (int i = 14; i < 22; i++)
			plan[i] = '{REQ_READ, 10'(i * 37), 1'b0, anyv};
		plan[22] = '{REQ_READ,   10'd0,    1'b1, none_left};
		plan[23] = '{REQ_APPEND, 10'd0,    1'b0, anyv};
		plan[24] = '{REQ_READ,   10'd0,    1'b0, anyv};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_N; i++)
			send_req(plan[i].rt, plan[i].tl, plan[i].typed, plan[i].want, 1'b0);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = ($urandom_range(0, 3) == 0);
			case (phase_mix[ph])
				MIX_APPEND_BURST: rd_pct = 3;
				MIX_READ_HEAVY:   rd_pct = 80;
				default:          rd_pct = 40;
			endcase
			for (int n = 0; n < phase_len[ph]; n++) begin
				rt = ($urandom_range(0, 99) < rd_pct) ? REQ_READ : REQ_APPEND;
				p = $urandom_range(0, 99);
				if (rt == REQ_READ)
					tl = $urandom_range(0, 1023);
				else if (p < 8)
					tl = $urandom_range(MAX_TEXT + 1, 1023);
				else if (p < 18)
					tl = $urandom_range(0, 15);
				else if (phase_mix[ph] == MIX_APPEND_BURST)
					tl = $urandom_range(600, MAX_TEXT);
				else
					tl = $urandom_range(0, MAX_TEXT);
				send_req(rt, tl, 1'b0, anyv, quiet);
			end
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("variable_record_ring_space_manager_tb passed");
		else
			$display("variable_record_ring_space_manager_tb failed");
		$finish;
	end

endmodule
`default_nettype wire
